// File: hdl/irpw_pkg.sv
// Shared types, constants and helpers for the IR pulse-width receiver.
// No dependencies; every other file in hdl/ uses this package.
package irpw_pkg;

  localparam int COUNT_BITS = 16;   // low/high time counters, saturating
  localparam int INDEX_BITS = 8;    // bit counter, wraps

  localparam int LEN_W   = 10;      // mark/space length registers
  localparam int TOL_W   = 8;       // tolerance register
  localparam int CFG_W   = 10;      // config write data, widest register
  localparam int CFG_IDX_W = 3;     // five registers
  localparam int BIT_IDX_W = 8;     // bit_index output field

  localparam int TIMEOUT_SHIFT = 3; // end of packet after 8 zero-mark lengths

  // wide enough for count + tolerance and for zero_mark_len << 3 without wrap
  localparam int WIN_W = ((COUNT_BITS > LEN_W + TIMEOUT_SHIFT) ?
                          COUNT_BITS : (LEN_W + TIMEOUT_SHIFT)) + 1;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [TOL_W-1:0]      tol_t;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_FALL = 2'd1,
    ACT_RISE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_START = 3'd1,
    EV_BIT   = 3'd2,
    EV_DONE  = 3'd3,
    EV_ERROR = 3'd4
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_MARK  = 3'd0,
    REG_ONE_MARK   = 3'd1,
    REG_START_MARK = 3'd2,
    REG_SPACE      = 3'd3,
    REG_TOLERANCE  = 3'd4
  } reg_idx_e;

  localparam len_t RST_ZERO_MARK  = len_t'(10);
  localparam len_t RST_ONE_MARK   = len_t'(20);
  localparam len_t RST_START_MARK = len_t'(40);
  localparam len_t RST_SPACE      = len_t'(10);
  localparam tol_t RST_TOLERANCE  = tol_t'(3);

  typedef struct packed {
    len_t zero_mark_len;
    len_t one_mark_len;
    len_t start_mark_len;
    len_t space_len;
    tol_t tolerance;
  } cfg_t;

  // strict window: nominal - tol < count < nominal + tol, no wrap
  function automatic logic in_window(cnt_t count, len_t nominal, tol_t tol);
    logic [WIN_W-1:0] c_w;
    logic [WIN_W-1:0] n_w;
    logic [WIN_W-1:0] t_w;
    c_w = WIN_W'(count);
    n_w = WIN_W'(nominal);
    t_w = WIN_W'(tol);
    return (c_w < n_w + t_w) && (c_w + t_w > n_w);
  endfunction

  function automatic logic [BIT_IDX_W-1:0] to_bit_index(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[BIT_IDX_W-1:0];
  endfunction

endpackage

// File: hdl/irpw_if.sv
// Valid/ready channel interfaces for the IR pulse-width receiver.
// Depends on irpw_pkg for field widths.
interface irpw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       line_level;

  modport source (output valid, output action, output line_level, input ready);
  modport sink   (input valid, input action, input line_level, output ready);
endinterface

interface irpw_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    event_res;
  logic                          bit_value;
  logic [irpw_pkg::BIT_IDX_W-1:0] bit_index;

  modport source (output valid, output event_res, output bit_value, output bit_index,
                  input ready);
  modport sink   (input valid, input event_res, input bit_value, input bit_index,
                  output ready);
endinterface

// File: hdl/irpw_cfg_regs.sv
// Configuration register file: five timing registers written by index.
// Depends on irpw_pkg.
module irpw_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [irpw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [irpw_pkg::CFG_W-1:0]     cfg_wdata_i,
  output irpw_pkg::cfg_t                 cfg_o
);

  irpw_pkg::cfg_t cfg_q;
  irpw_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        irpw_pkg::REG_ZERO_MARK:  cfg_d.zero_mark_len  = cfg_wdata_i[irpw_pkg::LEN_W-1:0];
        irpw_pkg::REG_ONE_MARK:   cfg_d.one_mark_len   = cfg_wdata_i[irpw_pkg::LEN_W-1:0];
        irpw_pkg::REG_START_MARK: cfg_d.start_mark_len = cfg_wdata_i[irpw_pkg::LEN_W-1:0];
        irpw_pkg::REG_SPACE:      cfg_d.space_len      = cfg_wdata_i[irpw_pkg::LEN_W-1:0];
        irpw_pkg::REG_TOLERANCE:  cfg_d.tolerance      = cfg_wdata_i[irpw_pkg::TOL_W-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_mark_len  <= irpw_pkg::RST_ZERO_MARK;
      cfg_q.one_mark_len   <= irpw_pkg::RST_ONE_MARK;
      cfg_q.start_mark_len <= irpw_pkg::RST_START_MARK;
      cfg_q.space_len      <= irpw_pkg::RST_SPACE;
      cfg_q.tolerance      <= irpw_pkg::RST_TOLERANCE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/irpw_decoder.sv
// Decoder datapath: input register, receive state, pulse classification and
// result register. Depends on irpw_pkg and the channel interfaces.
module irpw_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  irpw_pkg::cfg_t cfg_i,
  irpw_in_if.sink        in_ch,
  irpw_out_if.source     out_ch
);

  // input register
  logic       in_valid_q;
  logic [1:0] action_q;
  logic       level_q;

  // receive state
  logic             receiving_q, receiving_d;
  irpw_pkg::cnt_t   low_q, low_d;
  irpw_pkg::cnt_t   high_q, high_d;
  irpw_pkg::idx_t   bit_cnt_q, bit_cnt_d;

  // result register
  logic                           out_valid_q;
  logic [2:0]                     ev_q, ev_d;
  logic                           bitv_q, bitv_d;
  logic [irpw_pkg::BIT_IDX_W-1:0] bidx_q, bidx_d;

  logic advance;
  logic proc;
  logic in_accept;
  logic is_zero;
  logic is_one;
  logic is_start;
  logic space_ok;
  logic timeout;
  irpw_pkg::cnt_t high_inc;

  assign advance   = !out_valid_q || out_ch.ready;
  assign proc      = in_valid_q && advance;
  assign in_ch.ready = !in_valid_q || advance;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign is_zero  = irpw_pkg::in_window(low_q, cfg_i.zero_mark_len, cfg_i.tolerance);
  assign is_one   = irpw_pkg::in_window(low_q, cfg_i.one_mark_len, cfg_i.tolerance);
  assign is_start = irpw_pkg::in_window(low_q, cfg_i.start_mark_len, cfg_i.tolerance);
  assign space_ok = irpw_pkg::in_window(high_q, cfg_i.space_len, cfg_i.tolerance);

  assign high_inc = (high_q != '1) ? high_q + 1'b1 : high_q;
  assign timeout  = irpw_pkg::WIN_W'(high_inc) >
                    (irpw_pkg::WIN_W'(cfg_i.zero_mark_len) << irpw_pkg::TIMEOUT_SHIFT);

  always_comb begin
    receiving_d = receiving_q;
    low_d       = low_q;
    high_d      = high_q;
    bit_cnt_d   = bit_cnt_q;
    ev_d        = irpw_pkg::EV_NONE;
    bitv_d      = 1'b0;
    bidx_d      = '0;
    case (action_q)
      irpw_pkg::ACT_TICK: begin
        if (!level_q) begin
          if (low_q != '1) low_d = low_q + 1'b1;
        end else begin
          high_d = high_inc;
          if (receiving_q && timeout) begin
            receiving_d = 1'b0;
            ev_d        = irpw_pkg::EV_DONE;
          end
        end
      end
      irpw_pkg::ACT_FALL: begin
        if (receiving_q && !space_ok) begin
          receiving_d = 1'b0;
          bit_cnt_d   = '0;
          ev_d        = irpw_pkg::EV_ERROR;
        end
        low_d  = '0;
        high_d = '0;
      end
      irpw_pkg::ACT_RISE: begin
        if (receiving_q) begin
          if (is_zero || is_one) begin
            ev_d      = irpw_pkg::EV_BIT;
            bitv_d    = !is_zero;
            bidx_d    = irpw_pkg::to_bit_index(bit_cnt_q);
            bit_cnt_d = bit_cnt_q + 1'b1;
          end else begin
            receiving_d = 1'b0;
            bit_cnt_d   = '0;
            ev_d        = irpw_pkg::EV_ERROR;
          end
        end else if (is_start) begin
          receiving_d = 1'b1;
          bit_cnt_d   = '0;
          ev_d        = irpw_pkg::EV_START;
        end
        low_d  = '0;
        high_d = '0;
      end
      default: ; // undefined action: no change, event none
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      receiving_q <= 1'b0;
      low_q       <= '0;
      high_q      <= '0;
      bit_cnt_q   <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
        receiving_q <= receiving_d;
        low_q       <= low_d;
        high_q      <= high_d;
        bit_cnt_q   <= bit_cnt_d;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= in_ch.action;
      level_q  <= in_ch.line_level;
    end
    if (proc) begin
      ev_q   <= ev_d;
      bitv_q <= bitv_d;
      bidx_q <= bidx_d;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.event_res = ev_q;
  assign out_ch.bit_value = bitv_q;
  assign out_ch.bit_index = bidx_q;

endmodule

// File: hdl/ir_pulse_width_receiver_core.sv
// Top level of the IR pulse-width receiver: config registers plus decoder.
// Depends on irpw_pkg, irpw_if, irpw_cfg_regs and irpw_decoder.
//
//   channel   dir  beat payload                           handshake
//   in_ch     in   action[1:0], line_level               valid/ready
//   out_ch    out  event_res[2:0], bit_value, bit_index  valid/ready
//   cfg_*     in   cfg_idx_i[2:0], cfg_wdata_i[9:0]       cfg_we_i, no wait
//
// One beat in, one beat out: one beat per cycle while out_ch is not stalled.
// Each beat passes the input register, then the result register.
// The receive state (counters, bit index) advances once per beat as it moves
// from the input register into the result register.
// A stalled output holds its result and lets one more input beat wait in the
// input register. rst_ni clears state and loads the register defaults.
module ir_pulse_width_receiver_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  irpw_in_if.sink                        in_ch,
  irpw_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [irpw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [irpw_pkg::CFG_W-1:0]     cfg_wdata_i
);

  irpw_pkg::cfg_t cfg;

  irpw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irpw_decoder u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// File: hdl/irpw_checker.sv
// Port-level checks for the IR pulse-width receiver, bound to the top level.
// Depends on irpw_pkg and ir_pulse_width_receiver_core.
module irpw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [2:0]                     event_res_i,
  input logic                           bit_value_i,
  input logic [irpw_pkg::BIT_IDX_W-1:0] bit_index_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(event_res_i) && $stable(bit_value_i) && $stable(bit_index_i))
    else $error("result beat changed while stalled");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_res_i <= irpw_pkg::EV_ERROR)
    else $error("event code out of range");

  a_bit_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i != irpw_pkg::EV_BIT |-> !bit_value_i)
    else $error("bit value set on non-bit event");

  a_bit_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i != irpw_pkg::EV_BIT |-> bit_index_i == '0)
    else $error("bit index set on non-bit event");

endmodule

bind ir_pulse_width_receiver_core irpw_checker u_irpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .event_res_i (out_ch.event_res),
  .bit_value_i (out_ch.bit_value),
  .bit_index_i (out_ch.bit_index)
);

// File: dv/tb_top.sv
// Self-checking testbench for ir_pulse_width_receiver_core: drives tick and edge beats,
// predicts each decoder event in a local copy of the receive state and compares it.
// Depends on irpw_pkg, the irpw_if channel interfaces and the RTL under hdl/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                     ACT_UNDEF  = 2'd3;  // unused action code
  localparam logic [irpw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // beyond the register file
  localparam int PACKET_GAP_FACTOR = 8;
  localparam int DRAIN_CYCLES      = 6;
  localparam int STALL_LIMIT       = 2000;
  localparam int HOLD_OFF_CYCLES   = 400;

  typedef struct packed {
    irpw_pkg::event_e                 ev;
    logic                             bitv;
    logic [irpw_pkg::BIT_IDX_W-1:0]   idx;
  } decoded_event_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [irpw_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [irpw_pkg::CFG_W-1:0]     cfg_wdata;

  irpw_in_if  in_if ();
  irpw_out_if out_if ();

  ir_pulse_width_receiver_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // decoder shadow state
  logic             rx_active;
  irpw_pkg::cnt_t   low_ticks;
  irpw_pkg::cnt_t   high_ticks;
  irpw_pkg::idx_t   bit_pos;
  irpw_pkg::cfg_t   cfg_shadow;

  decoded_event_t pending_events[$];
  int             error_count;
  int             items_sent;
  bit             idle_en;
  int             rx_wait;
  int             hold_cycles;
  int             quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // strict window, evaluated wide so nothing wraps
  function automatic logic fits_window(irpw_pkg::cnt_t count, irpw_pkg::len_t nominal);
    int c;
    int n;
    int t;
    c = int'(count);
    n = int'(nominal);
    t = int'(cfg_shadow.tolerance);
    return (c < n + t) && (c + t > n);
  endfunction

  function automatic decoded_event_t decode_step(logic [1:0] act, logic level);
    decoded_event_t r;
    logic           as_zero;
    r.ev   = irpw_pkg::EV_NONE;
    r.bitv = 1'b0;
    r.idx  = '0;
    case (act)
      irpw_pkg::ACT_TICK: begin
        if (!level) begin
          if (low_ticks != '1) low_ticks = low_ticks + 1'b1;
        end else begin
          if (high_ticks != '1) high_ticks = high_ticks + 1'b1;
          if (rx_active && int'(high_ticks) >
              PACKET_GAP_FACTOR * int'(cfg_shadow.zero_mark_len)) begin
            rx_active = 1'b0;
            r.ev      = irpw_pkg::EV_DONE;
          end
        end
      end
      irpw_pkg::ACT_FALL: begin
        if (rx_active && !fits_window(high_ticks, cfg_shadow.space_len)) begin
          rx_active = 1'b0;
          bit_pos   = '0;
          r.ev      = irpw_pkg::EV_ERROR;
        end
        low_ticks  = '0;
        high_ticks = '0;
      end
      irpw_pkg::ACT_RISE: begin
        if (rx_active) begin
          as_zero = fits_window(low_ticks, cfg_shadow.zero_mark_len);
          if (as_zero || fits_window(low_ticks, cfg_shadow.one_mark_len)) begin
            r.ev    = irpw_pkg::EV_BIT;
            r.bitv  = !as_zero;
            r.idx   = irpw_pkg::BIT_IDX_W'(bit_pos);
            bit_pos = bit_pos + 1'b1;
          end else begin
            rx_active = 1'b0;
            bit_pos   = '0;
            r.ev      = irpw_pkg::EV_ERROR;
          end
        end else if (fits_window(low_ticks, cfg_shadow.start_mark_len)) begin
          rx_active = 1'b1;
          bit_pos   = '0;
          r.ev      = irpw_pkg::EV_START;
        end
        low_ticks  = '0;
        high_ticks = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(logic [1:0] act, logic level);
    int gap;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.line_level <= level;
    do @(posedge clk_i); while (!in_if.ready);
    pending_events.push_back(decode_step(act, level));
    items_sent++;
  endtask

  task automatic send_run(logic level, int count);
    repeat (count) send_beat(irpw_pkg::ACT_TICK, level);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [irpw_pkg::CFG_IDX_W-1:0] idx,
                           logic [irpw_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      irpw_pkg::REG_ZERO_MARK:  cfg_shadow.zero_mark_len  = irpw_pkg::len_t'(data);
      irpw_pkg::REG_ONE_MARK:   cfg_shadow.one_mark_len   = irpw_pkg::len_t'(data);
      irpw_pkg::REG_START_MARK: cfg_shadow.start_mark_len = irpw_pkg::len_t'(data);
      irpw_pkg::REG_SPACE:      cfg_shadow.space_len      = irpw_pkg::len_t'(data);
      irpw_pkg::REG_TOLERANCE:  cfg_shadow.tolerance      = irpw_pkg::tol_t'(data);
      default: ;
    endcase
  endtask

  task automatic set_config(int zero_len, int one_len, int start_len, int space, int tol);
    drain_results();
    write_reg(irpw_pkg::REG_ZERO_MARK, irpw_pkg::CFG_W'(zero_len));
    write_reg(irpw_pkg::REG_ONE_MARK, irpw_pkg::CFG_W'(one_len));
    write_reg(irpw_pkg::REG_START_MARK, irpw_pkg::CFG_W'(start_len));
    write_reg(irpw_pkg::REG_SPACE, irpw_pkg::CFG_W'(space));
    write_reg(irpw_pkg::REG_TOLERANCE, irpw_pkg::CFG_W'(tol));
  endtask

  // end any open packet and clear both counters
  task automatic close_packet();
    send_run(1'b1, PACKET_GAP_FACTOR * int'(cfg_shadow.zero_mark_len) + 1);
    send_beat(irpw_pkg::ACT_FALL, 1'b0);
  endtask

  // mostly inside the window, now and then just outside it
  function automatic int pick_len(int nominal, int run_cap);
    int t;
    int v;
    t = int'(cfg_shadow.tolerance);
    if ($urandom_range(0, 9) == 0) v = nominal + int'($urandom_range(0, 2 * t + 4)) - (t + 2);
    else if (t == 0) v = nominal;
    else v = nominal + int'($urandom_range(0, 2 * t - 2)) - (t - 1);
    if (v < 0) v = 0;
    if (v > run_cap) v = run_cap;
    return v;
  endfunction

  task automatic send_packet(int n_bits, int run_cap);
    int   b;
    logic one_bit;
    send_run(1'b0, pick_len(int'(cfg_shadow.start_mark_len), run_cap));
    send_beat(irpw_pkg::ACT_RISE, 1'($urandom_range(0, 1)));
    for (b = 0; b < n_bits; b++) begin
      send_run(1'b1, pick_len(int'(cfg_shadow.space_len), run_cap));
      send_beat(irpw_pkg::ACT_FALL, 1'($urandom_range(0, 1)));
      one_bit = 1'($urandom_range(0, 1));
      send_run(1'b0, pick_len(one_bit ? int'(cfg_shadow.one_mark_len) :
                                        int'(cfg_shadow.zero_mark_len), run_cap));
      send_beat(irpw_pkg::ACT_RISE, 1'($urandom_range(0, 1)));
    end
    // sometimes cut the packet short and run straight into the next one
    if ($urandom_range(0, 5) != 0)
      send_run(1'b1, PACKET_GAP_FACTOR * int'(cfg_shadow.zero_mark_len) + 1 +
                     $urandom_range(0, 3));
  endtask

  task automatic send_noise(int count);
    int         k;
    int         pick;
    logic [1:0] act;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) act = irpw_pkg::ACT_TICK;
      else if (pick < 8) act = irpw_pkg::ACT_FALL;
      else if (pick < 9) act = irpw_pkg::ACT_RISE;
      else act = ACT_UNDEF;
      send_beat(act, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int budget, int run_cap, bit packets_on);
    int first;
    first = items_sent;
    while (items_sent - first < budget) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if (!packets_on || $urandom_range(0, 4) == 0) send_noise($urandom_range(1, 8));
      else send_packet($urandom_range(1, 8), run_cap);
    end
  endtask

  task automatic test_reset_defaults();
    run_phase(120, 64, 1'b1);
  endtask

  task automatic test_basic_packet();
    set_config(1, 2, 3, 1, 1);  // tolerance 1: only the nominal count matches
    close_packet();
    send_beat(ACT_UNDEF, 1'b1);
    send_beat(irpw_pkg::ACT_FALL, 1'b0);
    send_beat(irpw_pkg::ACT_RISE, 1'b1);  // empty mark while idle is ignored
    send_run(1'b0, 3);
    send_beat(irpw_pkg::ACT_RISE, 1'b0);
    send_run(1'b1, 1);
    send_beat(irpw_pkg::ACT_FALL, 1'b1);
    send_run(1'b0, 1);
    send_beat(irpw_pkg::ACT_RISE, 1'b0);
    send_run(1'b1, 1);
    send_beat(irpw_pkg::ACT_FALL, 1'b0);
    send_run(1'b0, 2);
    send_beat(irpw_pkg::ACT_RISE, 1'b1);
    send_run(1'b1, PACKET_GAP_FACTOR + 1);
  endtask

  task automatic test_packet_errors();
    set_config(1, 2, 3, 1, 1);
    close_packet();
    send_run(1'b0, 3);
    send_beat(irpw_pkg::ACT_RISE, 1'b0);
    send_beat(irpw_pkg::ACT_FALL, 1'b1);  // no space at all
    send_run(1'b0, 3);
    send_beat(irpw_pkg::ACT_RISE, 1'b1);
    send_run(1'b1, 1);
    send_beat(irpw_pkg::ACT_FALL, 1'b0);
    send_run(1'b0, 5);          // mark fits neither bit window
    send_beat(irpw_pkg::ACT_RISE, 1'b0);
    send_run(1'b1, 2);
    send_beat(irpw_pkg::ACT_FALL, 1'b1);  // idle again, space not checked
  endtask

  task automatic test_index_wrap();
    int k;
    // tolerance above the nominal drops the lower bound: every short mark is a zero
    set_config(1, 1023, 1, 1, 255);
    close_packet();
    send_beat(irpw_pkg::ACT_RISE, 1'b0);
    for (k = 0; k < 260; k++) begin
      send_beat(irpw_pkg::ACT_FALL, k[0]);
      send_beat(irpw_pkg::ACT_RISE, k[1]);
    end
    send_run(1'b1, PACKET_GAP_FACTOR + 1);
  endtask

  task automatic test_output_backpressure();
    set_config(2, 4, 6, 3, 2);
    close_packet();
    idle_en     = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    send_packet(6, 16);
  endtask

  task automatic test_random_settings();
    set_config(2, 4, 6, 3, 2);
    run_phase(150, 16, 1'b1);
    set_config(3, 6, 9, 2, 1);
    run_phase(150, 16, 1'b1);
    set_config(1, 1023, 1, 1, 10'h3FF);  // upper data bits drop on the tolerance write
    run_phase(150, 6, 1'b1);
    set_config(1023, 1023, 1023, 1023, 0);  // empty windows: nothing can start
    run_phase(60, 16, 1'b0);
    set_config(5, 7, 12, 4, 3);  // zero and one windows overlap
    write_reg(REG_UNUSED, 10'h3FF);
    run_phase(120, 20, 1'b1);
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else if (rx_wait > 0) begin
        out_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    decoded_event_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected beat: event_res %0d bit_value %0d bit_index %0d",
                   $time, out_if.event_res, out_if.bit_value, out_if.bit_index);
          error_count++;
        end else begin
          want = pending_events.pop_front();
          if (out_if.event_res !== want.ev) begin
            $display("%0t: event_res mismatch: expected %0d, got %0d",
                     $time, want.ev, out_if.event_res);
            error_count++;
          end
          if (out_if.bit_value !== want.bitv) begin
            $display("%0t: bit_value mismatch: expected %0d, got %0d",
                     $time, want.bitv, out_if.bit_value);
            error_count++;
          end
          if (out_if.bit_index !== want.idx) begin
            $display("%0t: bit_index mismatch: expected %0d, got %0d",
                     $time, want.idx, out_if.bit_index);
            error_count++;
          end
        end
        rx_wait = idle_en ? $urandom_range(0, 7) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = irpw_pkg::ACT_TICK;
    in_if.line_level = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = irpw_pkg::REG_ZERO_MARK;
    cfg_wdata        = '0;
    error_count      = 0;
    items_sent       = 0;
    idle_en          = 1'b1;
    rx_wait          = 0;
    hold_cycles      = 0;
    quiet_cycles     = 0;
    rx_active        = 1'b0;
    low_ticks        = '0;
    high_ticks       = '0;
    bit_pos          = '0;
    cfg_shadow.zero_mark_len  = irpw_pkg::RST_ZERO_MARK;
    cfg_shadow.one_mark_len   = irpw_pkg::RST_ONE_MARK;
    cfg_shadow.start_mark_len = irpw_pkg::RST_START_MARK;
    cfg_shadow.space_len      = irpw_pkg::RST_SPACE;
    cfg_shadow.tolerance      = irpw_pkg::RST_TOLERANCE;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_basic_packet();
    test_packet_errors();
    test_index_wrap();
    test_output_backpressure();
    test_random_settings();

    drain_results();
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
